### rtl/core/sfr_pkg.sv
// Shared constants and types for the stick frame receiver.
package sfr_pkg;

    localparam int FRAME_LEN  = 8;
    localparam int POS_W      = 3;
    localparam int BYTE_W     = 8;

    // Byte positions inside one frame.
    localparam int IDX_START    = 0;
    localparam int IDX_THROTTLE = 1;
    localparam int IDX_PITCH    = 2;
    localparam int IDX_YAW      = 3;
    localparam int IDX_ROLL     = 4;
    localparam int IDX_KILL     = 5;
    localparam int IDX_CHECK    = 6;

    // Positions inside the held raw value bank.
    localparam int NUM_HELD      = 5;
    localparam int HELD_THROTTLE = 0;
    localparam int HELD_PITCH    = 1;
    localparam int HELD_YAW      = 2;
    localparam int HELD_ROLL     = 3;
    localparam int HELD_KILL     = 4;

    // Stick dead zone edges.
    localparam int DEAD_LOW     = 120;
    localparam int DEAD_HIGH    = 134;
    localparam int DEAD_SPAN_HI = 255 - DEAD_HIGH;

    // Mapping arithmetic: product of full scale and distance, times 256, then divided by
    // the span through a rounded-up reciprocal that is exact for every numerator.
    localparam int FULL_W    = 7;
    localparam int DIST_W    = 7;
    localparam int PROD_W    = FULL_W + DIST_W;
    localparam int REF_FRAC  = 8;
    localparam int NUM_W     = PROD_W + REF_FRAC;
    localparam int DIV_SHIFT = NUM_W + DIST_W;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int QUOT_W    = 16;
    localparam logic [63:0] RECIP_LO =
        ((64'd1 << DIV_SHIFT) + 64'(DEAD_LOW) - 64'd1) / 64'(DEAD_LOW);
    localparam logic [63:0] RECIP_HI =
        ((64'd1 << DIV_SHIFT) + 64'(DEAD_SPAN_HI) - 64'd1) / 64'(DEAD_SPAN_HI);

    // Throttle percent: raw * 100 / 255 through an exact reciprocal.
    localparam int THR_SCALE   = 100;
    localparam int THR_DIV     = 255;
    localparam int THR_PROD_W  = 15;
    localparam int THR_SHIFT   = 23;
    localparam int THR_RECIP_W = 16;
    localparam int THR_PCT_W   = 7;
    localparam logic [63:0] THR_RECIP =
        ((64'd1 << THR_SHIFT) + 64'(THR_DIV) - 64'd1) / 64'(THR_DIV);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_MARKER   = 3'd0,
        CFG_END_MARKER     = 3'd1,
        CFG_KILL_THRESHOLD = 3'd2,
        CFG_MAX_ANGLE      = 3'd3,
        CFG_MAX_YAW_RATE   = 3'd4
    } cfg_index_t;

    // One axis after the first mapping stage.
    typedef struct packed {
        logic              neg;
        logic              sel_hi;
        logic [PROD_W-1:0] prod;
    } map_t;

endpackage

### rtl/core/sfr_ifs.sv
// Stream interfaces for received bytes and for decoded stick results.
interface sfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if;
    logic               valid;
    logic               ready;
    logic               frame_ok;
    logic [6:0]         throttle_pct;
    logic signed [13:0] roll_ref;
    logic signed [13:0] pitch_ref;
    logic signed [15:0] yaw_rate_ref;
    logic               emergency_stop;
    logic [31:0]        good_frames;
    logic [31:0]        bad_frames;

    modport source (
        output valid, output frame_ok, output throttle_pct, output roll_ref,
        output pitch_ref, output yaw_rate_ref, output emergency_stop,
        output good_frames, output bad_frames, input ready
    );
    modport sink (
        input valid, input frame_ok, input throttle_pct, input roll_ref,
        input pitch_ref, input yaw_rate_ref, input emergency_stop,
        input good_frames, input bad_frames, output ready
    );
endinterface

### rtl/core/stick_frame_receiver.sv
// Stick frame receiver: byte deframer, frame check and stick reference mapping.
//
// The block takes one received byte per beat on link and accepts a beat in every clock
// cycle in which link is ready. While idle it hunts for the start marker; the next
// seven beats complete an 8-byte frame (start, throttle, pitch, yaw rate, roll, kill
// switch, XOR checksum of the five data bytes, end). On the eighth byte the frame is
// checked against the current marker registers and checksum, the held raw values and the
// good or bad frame counter are updated, and exactly one result beat leaves on stick.
// A frame's result is registered in turn after its last byte is accepted: one register
// stage holds the check outcome, the next holds the full-scale times distance products,
// and the output register holds the references after a reciprocal multiply by the dead
// zone span. These three stages drain independently, so up to three results may wait
// while stick is stalled; link drops ready only when a frame is at its last byte, all
// three are occupied and stick is stalled. Bytes that do not finish a frame are always
// taken. Configuration registers are written through cfg_we, cfg_index and cfg_wdata
// and should only change while no frame result is in flight.
module stick_frame_receiver
    import sfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    sfr_byte_if.sink              link,
    sfr_result_if.source          stick
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    // Configuration registers.
    logic [7:0]        start_marker_reg;
    logic [7:0]        end_marker_reg;
    logic [7:0]        kill_threshold_reg;
    logic [4:0]        max_angle_reg;
    logic [FULL_W-1:0] max_yaw_rate_reg;

    // Deframer state.
    logic             collecting_reg, collecting_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       frame_reg [0:FRAME_LEN-2];
    logic [7:0]       held_reg [0:NUM_HELD-1];
    logic [31:0]      good_count_reg;
    logic [31:0]      bad_count_reg;

    logic             last_byte;
    logic             byte_fire;
    logic             start_hit;
    logic             frame_done;
    logic             frame_good;
    logic [7:0]       check_xor;

    // Result pipeline.
    logic                  s1_valid_reg;
    logic                  s1_ok_reg;
    logic                  s1_ready;
    logic                  s2_valid_reg;
    logic                  s2_ok_reg;
    map_t                  s2_roll_reg;
    map_t                  s2_pitch_reg;
    map_t                  s2_yaw_reg;
    logic [THR_PROD_W-1:0] s2_thr_reg;
    logic                  s2_estop_reg;
    logic [31:0]           s2_good_reg;
    logic [31:0]           s2_bad_reg;
    logic                  s2_ready;
    logic                  out_valid_reg;
    logic                  out_ready;

    logic                  out_ok_reg;
    logic [THR_PCT_W-1:0]  out_thr_reg;
    logic signed [13:0]    out_roll_reg;
    logic signed [13:0]    out_pitch_reg;
    logic signed [15:0]    out_yaw_reg;
    logic                  out_estop_reg;
    logic [31:0]           out_good_reg;
    logic [31:0]           out_bad_reg;

    logic [QUOT_W-1:0]     roll_q, pitch_q, yaw_q;
    logic [THR_PROD_W+THR_RECIP_W-1:0] thr_mul;

    // First mapping step: dead zone test, distance from the zone edge, times full scale.
    function automatic map_t map_axis(input logic [7:0] v, input logic [FULL_W-1:0] full);
        map_t       m;
        logic       lo;
        logic       hi;
        logic [7:0] gap;
        lo   = v < 8'(DEAD_LOW);
        hi   = v > 8'(DEAD_HIGH);
        gap  = lo ? (8'(DEAD_LOW) - v) : (v - 8'(DEAD_HIGH));
        m.neg    = lo;
        m.sel_hi = hi;
        m.prod   = (lo || hi) ? (PROD_W'(full) * PROD_W'(gap[DIST_W-1:0])) : '0;
        return m;
    endfunction

    // Second mapping step: times 256, divided by the span, sign applied.
    function automatic logic [QUOT_W-1:0] scale_axis(input map_t m);
        logic [NUM_W-1:0]         num;
        logic [RECIP_W-1:0]       recip;
        logic [NUM_W+RECIP_W-1:0] mul;
        logic [QUOT_W-1:0]        q;
        num   = {m.prod, {REF_FRAC{1'b0}}};
        recip = m.sel_hi ? RECIP_HI[RECIP_W-1:0] : RECIP_LO[RECIP_W-1:0];
        mul   = (NUM_W+RECIP_W)'(num) * (NUM_W+RECIP_W)'(recip);
        q     = mul[DIV_SHIFT +: QUOT_W];
        return m.neg ? (~q + 1'b1) : q;
    endfunction

    // Register writes; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg   <= 8'hAA;
            end_marker_reg     <= 8'h55;
            kill_threshold_reg <= 8'd128;
            max_angle_reg      <= 5'd5;
            max_yaw_rate_reg   <= 7'd36;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_MARKER:   start_marker_reg   <= cfg_wdata;
                CFG_END_MARKER:     end_marker_reg     <= cfg_wdata;
                CFG_KILL_THRESHOLD: kill_threshold_reg <= cfg_wdata;
                CFG_MAX_ANGLE:      max_angle_reg      <= cfg_wdata[4:0];
                CFG_MAX_YAW_RATE:   max_yaw_rate_reg   <= cfg_wdata[FULL_W-1:0];
                default:            ;
            endcase
        end
    end

    // A byte that finishes a frame needs room in the first result stage.
    assign last_byte = collecting_reg && (pos_reg == LAST_POS);
    assign link.ready = !last_byte || s1_ready;
    assign byte_fire  = link.valid && link.ready;
    assign start_hit  = !collecting_reg && (link.rx_byte == start_marker_reg);

    always_comb
    begin
        collecting_next = collecting_reg;
        pos_next        = pos_reg;
        frame_done      = 1'b0;
        if (byte_fire)
        begin
            if (!collecting_reg)
            begin
                if (start_hit)
                begin
                    collecting_next = 1'b1;
                    pos_next        = POS_W'(1);
                end
            end
            else if (last_byte)
            begin
                collecting_next = 1'b0;
                pos_next        = '0;
                frame_done      = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            pos_reg        <= '0;
        end
        else
        begin
            collecting_reg <= collecting_next;
            pos_reg        <= pos_next;
        end
    end

    // Frame bytes up to the checksum; the end byte is checked straight off the link.
    always_ff @(posedge clk)
    begin
        if (byte_fire && !last_byte && (collecting_reg || start_hit))
        begin
            frame_reg[pos_reg] <= link.rx_byte;
        end
    end

    assign check_xor = frame_reg[IDX_THROTTLE] ^ frame_reg[IDX_PITCH] ^ frame_reg[IDX_YAW]
                     ^ frame_reg[IDX_ROLL] ^ frame_reg[IDX_KILL];
    assign frame_good = (frame_reg[IDX_START] == start_marker_reg)
                     && (link.rx_byte == end_marker_reg)
                     && (frame_reg[IDX_CHECK] == check_xor);

    // Held values and counters change only when a frame completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_HELD; i++)
            begin
                held_reg[i] <= '0;
            end
            good_count_reg <= '0;
            bad_count_reg  <= '0;
        end
        else if (frame_done)
        begin
            if (frame_good)
            begin
                for (int i = 0; i < NUM_HELD; i++)
                begin
                    held_reg[i] <= frame_reg[i + IDX_THROTTLE];
                end
                good_count_reg <= good_count_reg + 32'd1;
            end
            else
            begin
                bad_count_reg <= bad_count_reg + 32'd1;
            end
        end
    end

    // Stage handshakes. A stage refills whenever its content moves on or it is empty.
    assign out_ready = !out_valid_reg || stick.ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_done)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s2_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // The held bank and counters cannot move while the first stage holds a result, so
    // the second stage reads them directly.
    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            s1_ok_reg <= frame_good;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_ok_reg    <= s1_ok_reg;
            s2_roll_reg  <= map_axis(held_reg[HELD_ROLL], FULL_W'(max_angle_reg));
            s2_pitch_reg <= map_axis(held_reg[HELD_PITCH], FULL_W'(max_angle_reg));
            s2_yaw_reg   <= map_axis(held_reg[HELD_YAW], max_yaw_rate_reg);
            s2_thr_reg   <= THR_PROD_W'(held_reg[HELD_THROTTLE]) * THR_PROD_W'(THR_SCALE);
            s2_estop_reg <= held_reg[HELD_KILL] < kill_threshold_reg;
            s2_good_reg  <= good_count_reg;
            s2_bad_reg   <= bad_count_reg;
        end
    end

    assign roll_q  = scale_axis(s2_roll_reg);
    assign pitch_q = scale_axis(s2_pitch_reg);
    assign yaw_q   = scale_axis(s2_yaw_reg);
    assign thr_mul = (THR_PROD_W+THR_RECIP_W)'(s2_thr_reg)
                   * (THR_PROD_W+THR_RECIP_W)'(THR_RECIP[THR_RECIP_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && out_ready)
        begin
            out_ok_reg    <= s2_ok_reg;
            out_thr_reg   <= thr_mul[THR_SHIFT +: THR_PCT_W];
            out_roll_reg  <= $signed(roll_q[13:0]);
            out_pitch_reg <= $signed(pitch_q[13:0]);
            out_yaw_reg   <= $signed(yaw_q);
            out_estop_reg <= s2_estop_reg;
            out_good_reg  <= s2_good_reg;
            out_bad_reg   <= s2_bad_reg;
        end
    end

    assign stick.valid          = out_valid_reg;
    assign stick.frame_ok       = out_ok_reg;
    assign stick.throttle_pct   = out_thr_reg;
    assign stick.roll_ref       = out_roll_reg;
    assign stick.pitch_ref      = out_pitch_reg;
    assign stick.yaw_rate_ref   = out_yaw_reg;
    assign stick.emergency_stop = out_estop_reg;
    assign stick.good_frames    = out_good_reg;
    assign stick.bad_frames     = out_bad_reg;

endmodule

### rtl/core/sfr_checker.sv
// Port-level assertions for the stick frame receiver and their bind.
module sfr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               link_valid,
    input logic               link_ready,
    input logic               stick_valid,
    input logic               stick_ready,
    input logic               stick_frame_ok,
    input logic [6:0]         stick_throttle_pct,
    input logic signed [13:0] stick_roll_ref,
    input logic signed [13:0] stick_pitch_ref,
    input logic signed [15:0] stick_yaw_rate_ref,
    input logic               stick_emergency_stop,
    input logic [31:0]        stick_good_frames,
    input logic [31:0]        stick_bad_frames
);

    logic [31:0] frame_total;

    assign frame_total = stick_good_frames + stick_bad_frames;

    // A stalled result keeps its beat.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stick_valid && !stick_ready |=> stick_valid && $stable({stick_frame_ok,
            stick_throttle_pct, stick_roll_ref, stick_pitch_ref, stick_yaw_rate_ref,
            stick_emergency_stop, stick_good_frames, stick_bad_frames}))
        else $error("stalled result beat changed");

    // The byte side only backs up when the result side is stalled.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !link_ready |-> stick_valid && !stick_ready)
        else $error("link not ready without a stalled result");

    // Back-to-back results belong to consecutive frames.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (stick_valid && stick_ready) ##1 stick_valid |->
            frame_total == $past(frame_total) + 32'd1)
        else $error("frame counters skipped or repeated a frame");

    // A result that appears on an idle output was started by an earlier accepted byte beat,
    // the byte that closed its frame, carried through the check, product and output registers.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stick_valid) |-> $past(link_valid && link_ready, 3))
        else $error("result appeared without a closing byte");

endmodule

bind stick_frame_receiver sfr_checker u_sfr_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .link_valid           (link.valid),
    .link_ready           (link.ready),
    .stick_valid          (stick.valid),
    .stick_ready          (stick.ready),
    .stick_frame_ok       (stick.frame_ok),
    .stick_throttle_pct   (stick.throttle_pct),
    .stick_roll_ref       (stick.roll_ref),
    .stick_pitch_ref      (stick.pitch_ref),
    .stick_yaw_rate_ref   (stick.yaw_rate_ref),
    .stick_emergency_stop (stick.emergency_stop),
    .stick_good_frames    (stick.good_frames),
    .stick_bad_frames     (stick.bad_frames)
);

### tb/sv/testbench.sv
// Self-checking testbench for the stick frame receiver: stimulus, prediction and checks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    // The settle time before a register write leaves a comfortable margin after the last
    // result of the drain has come out.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    // Longest run of cycles without any beat or write before the run is declared hung.
    localparam int QUIET_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 40;
    localparam int PAUSE_PCT     = 18;
    localparam int PHASE_BEATS   = 275;
    // The last STEADY_SPAN of every STEADY_PERIOD stretch runs with no idling at all.
    localparam int STEADY_PERIOD = 1600;
    localparam int STEADY_SPAN   = 400;

    // One entry of the link plan: a byte to send, a register write, or a full drain.
    typedef enum {STEP_BYTE, STEP_WRITE, STEP_DRAIN} step_kind_t;

    typedef struct {
        step_kind_t kind;
        logic [7:0] value;
        cfg_index_t reg_sel;
    } link_step_t;

    // Ways a generated frame can be spoiled.
    typedef enum {FLAW_NONE, FLAW_CHECK, FLAW_END, FLAW_BOTH} frame_flaw_t;

    typedef struct {
        logic               frame_ok;
        logic [6:0]         throttle_pct;
        logic signed [13:0] roll_ref;
        logic signed [13:0] pitch_ref;
        logic signed [15:0] yaw_rate_ref;
        logic               emergency_stop;
        logic [31:0]        good_frames;
        logic [31:0]        bad_frames;
    } stick_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    sfr_byte_if   link();
    sfr_result_if stick();

    stick_frame_receiver uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .link      (link),
        .stick     (stick)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------------------
    // Bookkeeping shared by the driver, the monitor and the stimulus builder.
    // ------------------------------------------------------------------------------------
    link_step_t    link_plan[$];
    stick_result_t awaited_results[$];

    bit beat_taken     = 1'b0;
    int settle_count   = 0;
    int cycle_no       = 0;
    int quiet_cycles   = 0;
    int mismatch_count = 0;
    int beats_in       = 0;
    int results_seen   = 0;
    int good_seen      = 0;
    int writes_seen    = 0;

    // ------------------------------------------------------------------------------------
    // Predictor state: a private copy of the registers and of the deframer.
    // ------------------------------------------------------------------------------------
    logic [7:0]  start_mark = 8'hAA;
    logic [7:0]  end_mark   = 8'h55;
    logic [7:0]  kill_level = 8'd128;
    logic [4:0]  angle_full = 5'd5;
    logic [6:0]  yaw_full   = 7'd36;

    bit          in_frame   = 1'b0;
    logic [2:0]  frame_pos  = '0;
    logic [7:0]  frame_buf[FRAME_LEN];
    logic [7:0]  held[NUM_HELD] = '{default: 8'd0};
    logic [31:0] good_count = '0;
    logic [31:0] bad_count  = '0;

    // ------------------------------------------------------------------------------------
    // Stimulus builder state: it tracks just enough of the framing to know where the
    // block will be when each planned byte arrives.
    // ------------------------------------------------------------------------------------
    logic [7:0] gen_start = 8'hAA;
    logic [7:0] gen_end   = 8'h55;
    logic [7:0] gen_kill  = 8'd128;
    int         gen_pos   = 0;
    int         gen_beats = 0;

    // Dead-zone mapping of one raw stick byte to a reference in 1/256 units, truncated
    // toward zero. All arithmetic is on non-negative integers, then the sign is applied.
    function automatic int stick_reference(input logic [7:0] raw, input int full);
        int level;
        level = int'(raw);
        if (level < DEAD_LOW)
            return -((256 * full * (DEAD_LOW - level)) / DEAD_LOW);
        if (level > DEAD_HIGH)
            return (256 * full * (level - DEAD_HIGH)) / DEAD_SPAN_HI;
        return 0;
    endfunction

    // Advance the deframer by one accepted byte; a completed frame queues its result.
    task automatic deframe_byte(input logic [7:0] rx);
        stick_result_t r;
        logic [7:0]    sum;
        bit            ok;
        if (!in_frame) begin
            // While hunting, only the start marker matters; anything else is dropped.
            if (rx == start_mark) begin
                frame_buf[IDX_START] = rx;
                frame_pos = 3'd1;
                in_frame = 1'b1;
            end
            return;
        end
        // Inside a frame every byte is data, a start marker included.
        frame_buf[frame_pos] = rx;
        if (frame_pos < FRAME_LEN - 1) begin
            frame_pos = frame_pos + 3'd1;
            return;
        end
        in_frame = 1'b0;
        frame_pos = '0;
        sum = frame_buf[IDX_THROTTLE] ^ frame_buf[IDX_PITCH] ^ frame_buf[IDX_YAW]
            ^ frame_buf[IDX_ROLL] ^ frame_buf[IDX_KILL];
        // The markers are judged against the registers as they stand now.
        ok = frame_buf[IDX_START] == start_mark && frame_buf[FRAME_LEN-1] == end_mark
            && frame_buf[IDX_CHECK] == sum;
        if (ok) begin
            for (int i = 0; i < NUM_HELD; i++)
                held[i] = frame_buf[i + 1];
            good_count = good_count + 32'd1;
        end else begin
            bad_count = bad_count + 32'd1;
        end
        r.frame_ok       = ok;
        r.throttle_pct   = 7'((int'(held[HELD_THROTTLE]) * THR_SCALE) / THR_DIV);
        r.roll_ref       = 14'(stick_reference(held[HELD_ROLL], angle_full));
        r.pitch_ref      = 14'(stick_reference(held[HELD_PITCH], angle_full));
        r.yaw_rate_ref   = 16'(stick_reference(held[HELD_YAW], yaw_full));
        r.emergency_stop = held[HELD_KILL] < kill_level;
        r.good_frames    = good_count;
        r.bad_frames     = bad_count;
        awaited_results.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic signed [63:0] got,
                               input logic signed [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d, %s is %0d, expected %0d",
                                      results_seen, name, got, want));
    endtask

    // ------------------------------------------------------------------------------------
    // Idling: both sides pause at random, except in a recurring steady window.
    // ------------------------------------------------------------------------------------
    function automatic bit pause_roll();
        if ((cycle_no % STEADY_PERIOD) >= STEADY_PERIOD - STEADY_SPAN)
            return 1'b0;
        return $urandom_range(99) < PAUSE_PCT;
    endfunction

    // ------------------------------------------------------------------------------------
    // Stimulus builder. These tasks only fill the plan; nothing here consumes time.
    // ------------------------------------------------------------------------------------
    task automatic plan_byte(input logic [7:0] b);
        link_plan.push_back('{STEP_BYTE, b, CFG_START_MARKER});
        // Bytes the block drops while hunting do not count toward the item budget.
        if (gen_pos == 0) begin
            if (b == gen_start) begin
                gen_pos = 1;
                gen_beats++;
            end
        end else begin
            gen_beats++;
            gen_pos = (gen_pos == FRAME_LEN - 1) ? 0 : gen_pos + 1;
        end
    endtask

    task automatic plan_drain();
        link_plan.push_back('{STEP_DRAIN, 8'd0, CFG_START_MARKER});
    endtask

    task automatic plan_write(input cfg_index_t sel, input logic [7:0] data);
        link_plan.push_back('{STEP_WRITE, data, sel});
        case (sel)
            CFG_START_MARKER:   gen_start = data;
            CFG_END_MARKER:     gen_end = data;
            CFG_KILL_THRESHOLD: gen_kill = data;
            default: ;
        endcase
    endtask

    // Drain the block, then rewrite every register.
    task automatic plan_setting(input logic [7:0] s, input logic [7:0] e, input logic [7:0] k,
                                input logic [7:0] a, input logic [7:0] y);
        plan_drain();
        plan_write(CFG_START_MARKER, s);
        plan_write(CFG_END_MARKER, e);
        plan_write(CFG_KILL_THRESHOLD, k);
        plan_write(CFG_MAX_ANGLE, a);
        plan_write(CFG_MAX_YAW_RATE, y);
    endtask

    task automatic plan_frame(input logic [7:0] th, input logic [7:0] pi, input logic [7:0] ya,
                              input logic [7:0] ro, input logic [7:0] ki,
                              input frame_flaw_t flaw);
        logic [7:0] sum;
        logic [7:0] tail;
        sum = th ^ pi ^ ya ^ ro ^ ki;
        tail = gen_end;
        if (flaw == FLAW_CHECK || flaw == FLAW_BOTH)
            sum = sum ^ 8'($urandom_range(1, 255));
        if (flaw == FLAW_END || flaw == FLAW_BOTH)
            tail = tail ^ 8'($urandom_range(1, 255));
        plan_byte(gen_start);
        plan_byte(th);
        plan_byte(pi);
        plan_byte(ya);
        plan_byte(ro);
        plan_byte(ki);
        plan_byte(sum);
        plan_byte(tail);
    endtask

    // Stick bytes lean toward the rails and the dead-zone edges.
    function automatic logic [7:0] stick_pick();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'(DEAD_LOW - 1);
            3: return 8'(DEAD_LOW);
            4: return 8'(DEAD_HIGH);
            5: return 8'(DEAD_HIGH + 1);
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] kill_pick();
        case ($urandom_range(3))
            0: return gen_kill;
            1: return gen_kill - 8'd1;
            default: return stick_pick();
        endcase
    endfunction

    // Mostly clean frames with random content, plus spoiled frames, line noise,
    // truncated frames and the odd full drain of the block.
    task automatic plan_traffic(input int budget);
        int         goal;
        int         sel;
        logic [7:0] junk;
        goal = gen_beats + budget;
        while (gen_beats < goal) begin
            sel = $urandom_range(99);
            if (gen_pos != 0 && $urandom_range(4) != 0) begin
                // Finish a frame left open so the next clean frame lines up.
                while (gen_pos != 0)
                    plan_byte(8'($urandom_range(255)));
            end else if (sel < 72) begin
                plan_frame(stick_pick(), stick_pick(), stick_pick(), stick_pick(),
                           kill_pick(), FLAW_NONE);
            end else if (sel < 84) begin
                plan_frame(stick_pick(), stick_pick(), stick_pick(), stick_pick(),
                           kill_pick(), frame_flaw_t'($urandom_range(1, 3)));
            end else if (sel < 92) begin
                repeat ($urandom_range(1, 4)) begin
                    junk = 8'($urandom_range(255));
                    if (junk == gen_start)
                        junk = ~junk;
                    plan_byte(junk);
                end
            end else if (sel < 98) begin
                plan_byte(gen_start);
                repeat ($urandom_range(1, 6))
                    plan_byte(stick_pick());
            end else begin
                plan_drain();
            end
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Driver: link bytes and register writes change on the falling edge. A byte stays
    // on the link until the monitor has seen it accepted.
    // ------------------------------------------------------------------------------------
    always @(negedge clk) begin : link_driver
        logic                  next_valid;
        logic [7:0]            next_byte;
        logic                  next_we;
        logic [CFG_IDX_W-1:0]  next_index;
        logic [CFG_DATA_W-1:0] next_data;
        next_valid = link.valid;
        next_byte  = link.rx_byte;
        next_we    = 1'b0;
        next_index = cfg_index;
        next_data  = cfg_wdata;
        if (rst_n) begin
            if (beat_taken) begin
                link_plan.delete(0);
                beat_taken = 1'b0;
                next_valid = 1'b0;
            end
            if (!next_valid && link_plan.size() > 0) begin
                case (link_plan[0].kind)
                    STEP_BYTE: begin
                        if (!pause_roll()) begin
                            next_valid = 1'b1;
                            next_byte = link_plan[0].value;
                        end
                    end
                    STEP_WRITE: begin
                        next_we = 1'b1;
                        next_index = link_plan[0].reg_sel;
                        next_data = link_plan[0].value;
                        link_plan.delete(0);
                    end
                    STEP_DRAIN: begin
                        // Hold off until every result is in, then let the pipeline settle.
                        if (awaited_results.size() != 0) begin
                            settle_count = 0;
                        end else if (settle_count >= SETTLE_CYCLES) begin
                            settle_count = 0;
                            link_plan.delete(0);
                        end else begin
                            settle_count++;
                        end
                    end
                    default: ;
                endcase
            end
        end
        link.valid   <= next_valid;
        link.rx_byte <= next_byte;
        cfg_we       <= next_we;
        cfg_index    <= next_index;
        cfg_wdata    <= next_data;
    end

    // The result side stalls on its own random schedule.
    always @(negedge clk) begin : stick_stall
        if (rst_n)
            stick.ready <= !pause_roll();
    end

    // ------------------------------------------------------------------------------------
    // Monitor: on each rising edge, mirror register writes, feed accepted bytes to the
    // predictor and compare each accepted result beat with the oldest expectation.
    // ------------------------------------------------------------------------------------
    always @(posedge clk) begin : beat_monitor
        stick_result_t want;
        bit            busy;
        if (rst_n) begin
            busy = 1'b0;
            cycle_no++;
            if (cfg_we) begin
                busy = 1'b1;
                writes_seen++;
                case (cfg_index_t'(cfg_index))
                    CFG_START_MARKER:   start_mark = cfg_wdata;
                    CFG_END_MARKER:     end_mark = cfg_wdata;
                    CFG_KILL_THRESHOLD: kill_level = cfg_wdata;
                    CFG_MAX_ANGLE:      angle_full = cfg_wdata[4:0];
                    CFG_MAX_YAW_RATE:   yaw_full = cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (link.valid && link.ready) begin
                busy = 1'b1;
                beats_in++;
                beat_taken = 1'b1;
                deframe_byte(link.rx_byte);
            end
            if (stick.valid && stick.ready) begin
                busy = 1'b1;
                results_seen++;
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no frame outstanding",
                                              results_seen));
                end else begin
                    want = awaited_results.pop_front();
                    if (want.frame_ok)
                        good_seen++;
                    check_field("frame_ok", stick.frame_ok, want.frame_ok);
                    check_field("throttle_pct", stick.throttle_pct, want.throttle_pct);
                    check_field("roll_ref", stick.roll_ref, want.roll_ref);
                    check_field("pitch_ref", stick.pitch_ref, want.pitch_ref);
                    check_field("yaw_rate_ref", stick.yaw_rate_ref, want.yaw_rate_ref);
                    check_field("emergency_stop", stick.emergency_stop, want.emergency_stop);
                    check_field("good_frames", stick.good_frames, want.good_frames);
                    check_field("bad_frames", stick.bad_frames, want.bad_frames);
                end
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog: a long stretch with no beat and no write means the block has hung.
    always @(negedge clk) begin : watchdog
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Run stalled: %0d cycles without any beat, %0d results still due.",
                     quiet_cycles, awaited_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Stimulus: build the whole plan, release reset, then wait for the plan to run dry.
    // ------------------------------------------------------------------------------------
    initial begin : stimulus
        link.valid   = 1'b0;
        link.rx_byte = 8'd0;
        stick.ready  = 1'b0;

        // Directed part, starting from the reset register values.
        // Bytes other than the start marker are ignored while hunting.
        plan_byte(8'h00);
        plan_byte(8'hFF);
        // A clean frame with the fields at their rails and a start marker among the data.
        plan_frame(8'hFF, 8'h00, 8'hFF, gen_start, 8'h00, FLAW_NONE);
        // A frame with a bad checksum: the held values must stay as they were.
        plan_frame(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, FLAW_CHECK);
        // Start marker rewritten in the middle of a frame: the check sees the new value,
        // so the frame is rejected even though it was sent correctly.
        plan_byte(gen_start);
        plan_byte(8'h10);
        plan_byte(8'h20);
        plan_byte(8'h30);
        plan_drain();
        plan_write(CFG_START_MARKER, 8'h3C);
        plan_byte(8'h40);
        plan_byte(8'h50);
        plan_byte(8'h10 ^ 8'h20 ^ 8'h30 ^ 8'h40 ^ 8'h50);
        plan_byte(gen_end);

        // Random part, one register setting after another. Full scales of zero and the
        // widest values the fields hold lie outside the stated ranges and are included.
        plan_traffic(PHASE_BEATS);
        plan_setting(8'h00, 8'hFF, 8'h00, 8'h00, 8'h00);
        plan_traffic(PHASE_BEATS);
        plan_setting(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        plan_traffic(PHASE_BEATS);
        plan_setting(8'hAA, 8'h55, 8'd128, 8'd1, 8'd1);
        plan_traffic(PHASE_BEATS);
        plan_setting(8'hAA, 8'h55, 8'd128, 8'd30, 8'd90);
        plan_traffic(PHASE_BEATS);
        plan_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
        plan_traffic(PHASE_BEATS);
        plan_setting(8'hAA, 8'h55, 8'd128, 8'd5, 8'd36);
        plan_traffic(PHASE_BEATS);
        // Closing drain, so an empty plan also means every result has been checked.
        plan_drain();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        wait (link_plan.size() == 0 && awaited_results.size() == 0);
        // Anything that leaves the block after this point had no frame behind it.
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d byte beats and %0d register writes over seven settings.",
                 beats_in, writes_seen);
        $display("Checked %0d frame results (%0d good, %0d bad), %0d mismatches.",
                 results_seen, good_seen, results_seen - good_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
